### design/p2b_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2b_pkg
// Shared widths, register indexes and the quantizer result type for the
// pixel to bits packer.
// ----------------------------------------------------------------------------
package p2b_pkg;

	localparam int BYTE_W     = 8;
	localparam int CH_W       = 8;
	localparam int BPP_W      = 5;
	localparam int BITS_W     = 24;
	localparam int LEN_W      = 5;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 5;

	localparam logic [BPP_W-1:0] BPP_MAX   = 5'd24;
	localparam logic [BPP_W-1:0] BPP_RESET = 5'd1;

	localparam logic [CFG_IDX_W-1:0] REG_BPP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MSB = 2'd1;

	// pixel bits left-justified in bits, first bit sent at the top
	typedef struct packed {
		logic [BITS_W-1:0] bits;
		logic [LEN_W-1:0]  len;
	} quant_t;

endpackage

### design/p2b_quant.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p2b_quant
// Turns one pixel into its data bits: threshold of the average for one bit
// per pixel, otherwise per-component rounding to the split bit widths.
// ----------------------------------------------------------------------------
module p2b_quant
	import p2b_pkg::*;
(
	input  logic [CH_W-1:0]  red,
	input  logic [CH_W-1:0]  green,
	input  logic [CH_W-1:0]  blue,
	input  logic [BPP_W-1:0] bpp,
	output quant_t           result
);

	// round(c * (2^n - 1) / 255), division by 255 via shift-and-add
	function automatic logic [CH_W-1:0] quant_comp(logic [CH_W-1:0] c, logic [3:0] n);
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] s;
		x = (16'(c) << n) - 16'(c);
		y = x + 16'd127;
		s = y + 16'd1 + (y >> 8);
		return s[15:8];
	endfunction

	function automatic logic [CH_W-1:0] left_just(logic [CH_W-1:0] q, logic [3:0] n);
		return q << (4'd8 - n);
	endfunction

	logic [BPP_W-1:0]  eff_bpp;
	logic [3:0]        third;
	logic [BPP_W-1:0]  rem;
	logic [3:0]        n_r;
	logic [3:0]        n_g;
	logic [3:0]        n_b;
	logic [4:0]        off_b;
	logic [9:0]        ch_sum;
	logic [CH_W-1:0]   qj_r;
	logic [CH_W-1:0]   qj_g;
	logic [CH_W-1:0]   qj_b;
	logic [BITS_W-1:0] multi_bits;

	always_comb begin
		if (bpp == '0) begin
			eff_bpp = 5'd1;
		end else if (bpp > BPP_MAX) begin
			eff_bpp = BPP_MAX;
		end else begin
			eff_bpp = bpp;
		end
	end

	// bpp / 3 by threshold count
	always_comb begin
		third = '0;
		for (int i = 1; i <= 8; i++) begin
			if (eff_bpp >= 5'(3 * i)) begin
				third = third + 4'd1;
			end
		end
		rem = eff_bpp - 5'({third, 1'b0}) - 5'(third);
	end

	assign n_r   = third + 4'(rem != '0);
	assign n_g   = third + 4'(rem == 5'd2);
	assign n_b   = third;
	assign off_b = 5'(n_r) + 5'(n_g);

	assign qj_r = left_just(quant_comp(red, n_r), n_r);
	assign qj_g = left_just(quant_comp(green, n_g), n_g);
	assign qj_b = left_just(quant_comp(blue, n_b), n_b);

	assign multi_bits = {qj_r, 16'b0} | ({qj_g, 16'b0} >> n_r) | ({qj_b, 16'b0} >> off_b);

	assign ch_sum = 10'(red) + 10'(green) + 10'(blue);

	always_comb begin
		if (eff_bpp == 5'd1) begin
			result.bits = {ch_sum >= 10'd384, 23'b0};
		end else begin
			result.bits = multi_bits;
		end
		result.len = eff_bpp;
	end

endmodule

### design/pixel_to_bits_packer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_to_bits_packer_unit
// RGB pixels in, packed data bytes out.
// ----------------------------------------------------------------------------
// A pixel is registered, quantized to the configured pixel depth in the next
// stage, then merged into the byte packer, which hands every completed byte
// (up to three per pixel) to an output buffer that sends one byte per cycle
// while byte_stall is low. A pixel can be taken every cycle while each pixel
// completes at most one byte and byte_stall is low; otherwise the output port
// sets the pace. A pixel's bytes pass the input register, the quantized stage
// register and the output buffer on their way out. The partial byte is never
// flushed. Configuration writes are always ready and belong only between
// runs.
// ----------------------------------------------------------------------------
module pixel_to_bits_packer_unit
	import p2b_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pix_valid,
	output logic                  pix_stall,
	input  logic [CH_W-1:0]       red,
	input  logic [CH_W-1:0]       green,
	input  logic [CH_W-1:0]       blue,
	output logic                  byte_valid,
	input  logic                  byte_stall,
	output logic [BYTE_W-1:0]     byte_out,
	output logic                  last_of_run
);

	function automatic logic [BYTE_W-1:0] rev8(logic [BYTE_W-1:0] v);
		logic [BYTE_W-1:0] r;
		for (int i = 0; i < BYTE_W; i++) begin
			r[i] = v[BYTE_W-1-i];
		end
		return r;
	endfunction

	function automatic logic [BITS_W-1:0] rev24(logic [BITS_W-1:0] v);
		logic [BITS_W-1:0] r;
		for (int i = 0; i < BITS_W; i++) begin
			r[i] = v[BITS_W-1-i];
		end
		return r;
	endfunction

	logic [BPP_W-1:0]  bpp_q;
	logic              msb_q;

	logic              valid_s1;
	logic [CH_W-1:0]   red_s1;
	logic [CH_W-1:0]   green_s1;
	logic [CH_W-1:0]   blue_s1;

	quant_t            quant;
	logic              valid_s2;
	quant_t            quant_s2;

	logic [BYTE_W-1:0] part_q;
	logic [2:0]        bitcnt_q;

	logic              bund_valid_q;
	logic [BYTE_W-1:0] bund_byte_q [3];
	logic [1:0]        bund_cnt_q;
	logic [1:0]        bund_idx_q;

	logic [LEN_W-1:0]  total;
	logic [1:0]        nbytes;
	logic [31:0]       stream;
	logic [BYTE_W-1:0] pk_byte [4];
	logic              is_last;
	logic              pop;
	logic              bund_free;
	logic              adv_s2;
	logic              ready_s2;
	logic              adv_s1;
	logic              ready_s1;
	logic              pix_acc;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= BPP_RESET;
			msb_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BPP) begin
				bpp_q <= cfg_data;
			end else if (cfg_index == REG_MSB) begin
				msb_q <= cfg_data[0];
			end
		end
	end

	// handshake chain
	assign is_last   = (bund_idx_q + 2'd1) == bund_cnt_q;
	assign pop       = bund_valid_q && !byte_stall;
	assign bund_free = !bund_valid_q || (pop && is_last);
	assign adv_s2    = valid_s2 && ((nbytes == 2'd0) || bund_free);
	assign ready_s2  = !valid_s2 || adv_s2;
	assign adv_s1    = valid_s1 && ready_s2;
	assign ready_s1  = !valid_s1 || adv_s1;
	assign pix_stall = !ready_s1;
	assign pix_acc   = pix_valid && !pix_stall;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			red_s1   <= red;
			green_s1 <= green;
			blue_s1  <= blue;
		end
	end

	p2b_quant u_quant (
		.red    (red_s1),
		.green  (green_s1),
		.blue   (blue_s1),
		.bpp    (bpp_q),
		.result (quant)
	);

	// quantized stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			quant_s2 <= quant;
		end
	end

	// byte packer
	assign total  = LEN_W'(bitcnt_q) + quant_s2.len;
	assign nbytes = total[4:3];
	assign stream = 32'(rev24(quant_s2.bits)) << bitcnt_q;

	always_comb begin
		for (int b = 0; b < 4; b++) begin
			pk_byte[b] = msb_q ? rev8(stream[8*b +: 8]) : stream[8*b +: 8];
		end
		pk_byte[0] = pk_byte[0] | part_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q   <= '0;
			bitcnt_q <= '0;
		end else if (adv_s2) begin
			part_q   <= pk_byte[nbytes];
			bitcnt_q <= total[2:0];
		end
	end

	// output buffer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bund_valid_q <= 1'b0;
			bund_cnt_q   <= '0;
			bund_idx_q   <= '0;
		end else if (adv_s2 && (nbytes != 2'd0)) begin
			bund_valid_q <= 1'b1;
			bund_cnt_q   <= nbytes;
			bund_idx_q   <= '0;
		end else if (pop) begin
			if (is_last) begin
				bund_valid_q <= 1'b0;
			end else begin
				bund_idx_q <= bund_idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && (nbytes != 2'd0)) begin
			bund_byte_q[0] <= pk_byte[0];
			bund_byte_q[1] <= pk_byte[1];
			bund_byte_q[2] <= pk_byte[2];
		end
	end

	assign byte_valid  = bund_valid_q;
	assign byte_out    = bund_byte_q[bund_idx_q];
	assign last_of_run = is_last;

	// checks
	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !is_last |=> bund_valid_q)
		else $error("byte run ended early");

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		bund_valid_q |-> (bund_cnt_q != 2'd0) && (bund_idx_q < bund_cnt_q))
		else $error("output index outside run");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !adv_s2 |=> valid_s2 && $stable(quant_s2) && $stable(bitcnt_q))
		else $error("blocked pixel lost");

	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc |=> valid_s1)
		else $error("accepted pixel dropped");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 && (nbytes != 2'd0) |-> bund_free)
		else $error("output run overwritten");

endmodule
